// ----- hw/rtl/chi_pkg.sv -----
// Shared types and constants for the cuckoo hash insert unit.
// Used by chi_ctrl, chi_datapath and cuckoo_hash_insert; depends on nothing.
package chi_pkg;

   // Fixed field widths of the request and response ports
   localparam int KEY_FIELD_BITS = 32;
   localparam int POS_BITS       = 3;
   localparam int KICK_BITS      = 8;

   // Kick limit after reset
   localparam logic [KICK_BITS-1:0] MAX_KICKS_RESET = 8'd32;

   // Response status codes
   localparam logic STATUS_PLACED = 1'b0;
   localparam logic STATUS_FAILED = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic clear;    // write empty entry at clear counter, both tables
      logic load;     // capture request as carried item
      logic read;     // read current side's slot
      logic write;    // write carried item into current side's slot
      logic evict;    // take occupant as carried item, count kick, swap side
      logic finish;   // register response, strobe it
      logic fail;     // response reports homeless item
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic slot_full;   // slot just read holds a valid entry
      logic limit_hit;   // kick count has reached the limit
      logic clear_last;  // clearing pass at last entry
   } status_type;

endpackage

// ----- hw/rtl/chi_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
module chi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/chi_ctrl.sv -----
// Controller state machine for the cuckoo hash insert unit.
// Depends on chi_pkg for the command and status structs.
module chi_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  chi_pkg::status_type status,
   output chi_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_EVAL  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            priority if (!status.slot_full) begin
               // empty slot: place carried item and finish
               cmd.write  = 1'b1;
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.limit_hit) begin
               // no kick left: carried item stays homeless
               cmd.finish = 1'b1;
               cmd.fail   = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               // kick the occupant and try the other table
               cmd.write = 1'b1;
               cmd.evict = 1'b1;
               state_in  = ST_READ;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- hw/rtl/chi_datapath.sv -----
// Datapath for the cuckoo hash insert unit: both tables, carried item, kick
// counter, kick limit register and response registers. Uses chi_pkg, chi_ram.
module chi_datapath #(
   parameter int TABLE_DEPTH = 8,
   parameter int KEY_BITS    = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  chi_pkg::cmd_type                      cmd,
   output chi_pkg::status_type                   status,
   input  logic                                  csr_valid,
   input  logic [chi_pkg::KICK_BITS-1:0]         csr_data,
   input  logic [chi_pkg::KEY_FIELD_BITS-1:0]    req_new_key,
   input  logic [chi_pkg::POS_BITS-1:0]          req_hash_one_pos,
   input  logic [chi_pkg::POS_BITS-1:0]          req_hash_two_pos,
   output logic                                  rsp_valid,
   output logic                                  rsp_status,
   output logic [chi_pkg::KICK_BITS-1:0]         rsp_kick_count,
   output logic [chi_pkg::KEY_FIELD_BITS-1:0]    rsp_leftover_key,
   output logic [chi_pkg::POS_BITS-1:0]          rsp_leftover_pos_one,
   output logic [chi_pkg::POS_BITS-1:0]          rsp_leftover_pos_two
);

   localparam int PosW       = chi_pkg::POS_BITS;
   localparam int KickW      = chi_pkg::KICK_BITS;
   localparam int KeyFieldW  = chi_pkg::KEY_FIELD_BITS;
   localparam int IdxW       = $clog2(TABLE_DEPTH);
   localparam int EntryW     = 1 + KEY_BITS + 2 * PosW;
   localparam int DepthCap   = (TABLE_DEPTH > 8) ? 8 : TABLE_DEPTH;
   localparam logic [3:0] DepthNarrow = 4'(DepthCap);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

   // Slot number reduced modulo the table depth; at most seven subtractions
   function automatic logic [IdxW-1:0] slot_index(input logic [PosW-1:0] pos);
      logic [3:0] v;
      v = {1'b0, pos};
      for (int i = 0; i < 7; i++) begin
         if (v >= DepthNarrow) begin
            v = v - DepthNarrow;
         end
      end
      return IdxW'(v);
   endfunction

   logic [KickW-1:0]     max_kicks_ff;
   logic [IdxW-1:0]      clr_cnt_ff;
   logic [KEY_BITS-1:0]  carry_key_ff;
   logic [PosW-1:0]      carry_p1_ff;
   logic [PosW-1:0]      carry_p2_ff;
   logic                 side_ff;
   logic [KickW-1:0]     kicks_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_status_ff;
   logic [KickW-1:0]     rsp_kick_count_ff;
   logic [KeyFieldW-1:0] rsp_leftover_key_ff;
   logic [PosW-1:0]      rsp_leftover_pos_one_ff;
   logic [PosW-1:0]      rsp_leftover_pos_two_ff;

   logic [IdxW-1:0]      slot_addr;
   logic [IdxW-1:0]      wr_addr;
   logic [EntryW-1:0]    wr_data;
   logic [EntryW-1:0]    carry_entry;
   logic                 wr_one;
   logic                 wr_two;
   logic                 rd_one;
   logic                 rd_two;
   logic [EntryW-1:0]    rd_data_one;
   logic [EntryW-1:0]    rd_data_two;
   logic [EntryW-1:0]    occupant;

   // Table addressing: carried item's slot on the current side
   assign slot_addr   = side_ff ? slot_index(carry_p2_ff) : slot_index(carry_p1_ff);
   assign carry_entry = {1'b1, carry_key_ff, carry_p1_ff, carry_p2_ff};
   assign wr_addr     = cmd.clear ? clr_cnt_ff : slot_addr;
   assign wr_data     = cmd.clear ? '0 : carry_entry;
   assign wr_one      = cmd.clear || (cmd.write && !side_ff);
   assign wr_two      = cmd.clear || (cmd.write && side_ff);
   assign rd_one      = cmd.read && !side_ff;
   assign rd_two      = cmd.read && side_ff;

   chi_ram #(
      .WIDTH (EntryW),
      .DEPTH (TABLE_DEPTH)
   ) u_first_table (
      .clock   (clock),
      .wr_en   (wr_one),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_one),
      .rd_addr (slot_addr),
      .rd_data (rd_data_one)
   );

   chi_ram #(
      .WIDTH (EntryW),
      .DEPTH (TABLE_DEPTH)
   ) u_second_table (
      .clock   (clock),
      .wr_en   (wr_two),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_two),
      .rd_addr (slot_addr),
      .rd_data (rd_data_two)
   );

   assign occupant = side_ff ? rd_data_two : rd_data_one;

   // Status back to the controller
   assign status.slot_full  = occupant[EntryW-1];
   assign status.limit_hit  = (kicks_ff >= max_kicks_ff);
   assign status.clear_last = (clr_cnt_ff == LastIdx);

   // Kick limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_kicks_ff <= chi_pkg::MAX_KICKS_RESET;
      end else if (csr_valid) begin
         max_kicks_ff <= csr_data;
      end
   end

   // Clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // Carried item, side and kick count
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         carry_key_ff <= KEY_BITS'(req_new_key);
         carry_p1_ff  <= req_hash_one_pos;
         carry_p2_ff  <= req_hash_two_pos;
         side_ff      <= 1'b0;
         kicks_ff     <= '0;
      end else if (cmd.evict) begin
         carry_key_ff <= occupant[2*PosW +: KEY_BITS];
         carry_p1_ff  <= occupant[PosW +: PosW];
         carry_p2_ff  <= occupant[0 +: PosW];
         side_ff      <= !side_ff;
         kicks_ff     <= kicks_ff + 1'b1;
      end
   end

   // Response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff     <= cmd.fail ? chi_pkg::STATUS_FAILED : chi_pkg::STATUS_PLACED;
         rsp_kick_count_ff <= kicks_ff;
         if (cmd.fail) begin
            rsp_leftover_key_ff     <= KeyFieldW'(carry_key_ff);
            rsp_leftover_pos_one_ff <= carry_p1_ff;
            rsp_leftover_pos_two_ff <= carry_p2_ff;
         end else begin
            rsp_leftover_key_ff     <= '0;
            rsp_leftover_pos_one_ff <= '0;
            rsp_leftover_pos_two_ff <= '0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_kick_count       = rsp_kick_count_ff;
   assign rsp_leftover_key     = rsp_leftover_key_ff;
   assign rsp_leftover_pos_one = rsp_leftover_pos_one_ff;
   assign rsp_leftover_pos_two = rsp_leftover_pos_two_ff;

endmodule

// ----- hw/rtl/cuckoo_hash_insert.sv -----
// Two-table cuckoo hash insert unit; top level. Uses chi_pkg, chi_ctrl, chi_datapath.
// Each try is a registered table read, then an evaluate-and-write step; an
// insert with k kicks makes k+1 tries, and busy stays high through all of them.
// The response strobe is registered and shows in the cycle after the last try; a new start is taken in that cycle.
// Synchronous reset sets the kick limit to 32, then a clearing pass writes an empty
// entry to every slot of both tables with busy high. Results cannot be stalled.
module cuckoo_hash_insert #(
   parameter int TABLE_DEPTH = 8,
   parameter int KEY_BITS    = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [chi_pkg::KEY_FIELD_BITS-1:0] req_new_key,
   input  logic [chi_pkg::POS_BITS-1:0]       req_hash_one_pos,
   input  logic [chi_pkg::POS_BITS-1:0]       req_hash_two_pos,
   output logic                               rsp_valid,
   output logic                               rsp_status,
   output logic [chi_pkg::KICK_BITS-1:0]      rsp_kick_count,
   output logic [chi_pkg::KEY_FIELD_BITS-1:0] rsp_leftover_key,
   output logic [chi_pkg::POS_BITS-1:0]       rsp_leftover_pos_one,
   output logic [chi_pkg::POS_BITS-1:0]       rsp_leftover_pos_two,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [chi_pkg::KICK_BITS-1:0]      csr_data
);

   chi_pkg::cmd_type    cmd;
   chi_pkg::status_type status;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   chi_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   chi_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_valid            (csr_valid && csr_ready),
      .csr_data             (csr_data),
      .req_new_key          (req_new_key),
      .req_hash_one_pos     (req_hash_one_pos),
      .req_hash_two_pos     (req_hash_two_pos),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_kick_count       (rsp_kick_count),
      .rsp_leftover_key     (rsp_leftover_key),
      .rsp_leftover_pos_one (rsp_leftover_pos_one),
      .rsp_leftover_pos_two (rsp_leftover_pos_two)
   );

   // An accepted start always leads into the eviction walk
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("start accepted but controller did not go busy");

   // A response only follows a busy cycle and shows with the controller idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("response strobe outside end of insert");

   // Write and evict never coincide with a clearing pass or a load
   assert property (@(posedge clock) disable iff (reset)
      (cmd.write || cmd.evict) |-> (!cmd.clear && !cmd.load))
      else $error("table write overlaps clear or load");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for the two-table cuckoo hash insert unit.
// Depends on chi_pkg and cuckoo_hash_insert; keeps its own shadow tables.
`timescale 1ns / 100ps
module tb_top;

   localparam int KEY_FIELD_BITS = chi_pkg::KEY_FIELD_BITS;
   localparam int POS_BITS       = chi_pkg::POS_BITS;
   localparam int KICK_BITS      = chi_pkg::KICK_BITS;

   localparam int TBL_DEPTH   = 8;
   localparam int ITEM_TARGET = 1550;

   // One table entry and one insert outcome at the port widths
   typedef struct packed {
      logic                      valid;
      logic [KEY_FIELD_BITS-1:0] key;
      logic [POS_BITS-1:0]       pos_one;
      logic [POS_BITS-1:0]       pos_two;
   } slot_type;

   typedef struct packed {
      logic                      status;
      logic [KICK_BITS-1:0]      kicks;
      logic [KEY_FIELD_BITS-1:0] key;
      logic [POS_BITS-1:0]       pos_one;
      logic [POS_BITS-1:0]       pos_two;
   } outcome_type;

   typedef enum logic {STEP_INSERT, STEP_LIMIT} step_op_type;

   typedef struct packed {
      step_op_type               op;
      logic [KEY_FIELD_BITS-1:0] key;
      logic [POS_BITS-1:0]       pos_one;
      logic [POS_BITS-1:0]       pos_two;
      logic [KICK_BITS-1:0]      limit;
      logic                      typed;
      outcome_type               want;
   } step_type;

   localparam outcome_type NO_OUTCOME = '0;
   localparam outcome_type PLACED_NO_KICK =
      '{chi_pkg::STATUS_PLACED, 8'd0, 32'd0, 3'd0, 3'd0};

   // Directed plan: typed outcomes only where obvious, the rest predicted
   localparam step_type DIRECTED_PLAN [0:19] = '{
      '{STEP_INSERT, 32'h0000_0000, 3'd0, 3'd0, 8'd0, 1'b1, PLACED_NO_KICK},
      '{STEP_INSERT, 32'hFFFF_FFFF, 3'd7, 3'd7, 8'd0, 1'b1, PLACED_NO_KICK},
      '{STEP_INSERT, 32'hA5A5_A5A5, 3'd0, 3'd7, 8'd0, 1'b0, NO_OUTCOME},
      '{STEP_INSERT, 32'h5A5A_5A5A, 3'd0, 3'd0, 8'd0, 1'b0, NO_OUTCOME},
      // eviction loop on slot 0 of both tables, runs into the limit
      '{STEP_INSERT, 32'h1234_5678, 3'd0, 3'd0, 8'd0, 1'b0, NO_OUTCOME},
      '{STEP_INSERT, 32'h0F0F_0F0F, 3'd3, 3'd5, 8'd0, 1'b1, PLACED_NO_KICK},
      '{STEP_INSERT, 32'hF0F0_F0F0, 3'd3, 3'd5, 8'd0, 1'b0, NO_OUTCOME},
      // zero limit: occupied first slot fails at once, empty one still places
      '{STEP_LIMIT,  32'h0,         3'd0, 3'd0, 8'd0, 1'b0, NO_OUTCOME},
      '{STEP_INSERT, 32'h8765_4321, 3'd7, 3'd2, 8'd0, 1'b1,
        '{chi_pkg::STATUS_FAILED, 8'd0, 32'h8765_4321, 3'd7, 3'd2}},
      '{STEP_INSERT, 32'h0000_0001, 3'd1, 3'd1, 8'd0, 1'b1, PLACED_NO_KICK},
      // limit of one: an earlier evictee ends up homeless
      '{STEP_LIMIT,  32'h0,         3'd0, 3'd0, 8'd1, 1'b0, NO_OUTCOME},
      '{STEP_INSERT, 32'hDEAD_BEEF, 3'd3, 3'd6, 8'd0, 1'b0, NO_OUTCOME},
      '{STEP_LIMIT,  32'h0,         3'd0, 3'd0, 8'd255, 1'b0, NO_OUTCOME},
      '{STEP_INSERT, 32'hCAFE_F00D, 3'd0, 3'd0, 8'd0, 1'b0, NO_OUTCOME},
      '{STEP_INSERT, 32'h1357_9BDF, 3'd2, 3'd4, 8'd0, 1'b1, PLACED_NO_KICK},
      '{STEP_LIMIT,  32'h0,         3'd0, 3'd0, 8'd2, 1'b0, NO_OUTCOME},
      '{STEP_INSERT, 32'h2468_ACE0, 3'd4, 3'd3, 8'd0, 1'b1, PLACED_NO_KICK},
      '{STEP_INSERT, 32'h5555_5555, 3'd5, 3'd1, 8'd0, 1'b1, PLACED_NO_KICK},
      '{STEP_INSERT, 32'hAAAA_AAAA, 3'd6, 3'd6, 8'd0, 1'b1, PLACED_NO_KICK},
      '{STEP_INSERT, 32'h1111_1111, 3'd4, 3'd4, 8'd0, 1'b0, NO_OUTCOME}
   };

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [KEY_FIELD_BITS-1:0] req_new_key;
   logic [POS_BITS-1:0]       req_hash_one_pos;
   logic [POS_BITS-1:0]       req_hash_two_pos;
   logic                      rsp_valid;
   logic                      rsp_status;
   logic [KICK_BITS-1:0]      rsp_kick_count;
   logic [KEY_FIELD_BITS-1:0] rsp_leftover_key;
   logic [POS_BITS-1:0]       rsp_leftover_pos_one;
   logic [POS_BITS-1:0]       rsp_leftover_pos_two;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [KICK_BITS-1:0]      csr_data;

   // Shadow state of the block
   slot_type             shadow_one [TBL_DEPTH];
   slot_type             shadow_two [TBL_DEPTH];
   logic [KICK_BITS-1:0] kick_limit = chi_pkg::MAX_KICKS_RESET;

   outcome_type               pending_outcomes [$];
   int unsigned               fault_count = 0;
   int unsigned               inserts_sent = 0;
   logic [KEY_FIELD_BITS-1:0] recent_key = '0;

   cuckoo_hash_insert #(
      .TABLE_DEPTH (TBL_DEPTH),
      .KEY_BITS    (32)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_new_key          (req_new_key),
      .req_hash_one_pos     (req_hash_one_pos),
      .req_hash_two_pos     (req_hash_two_pos),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_kick_count       (rsp_kick_count),
      .rsp_leftover_key     (rsp_leftover_key),
      .rsp_leftover_pos_one (rsp_leftover_pos_one),
      .rsp_leftover_pos_two (rsp_leftover_pos_two),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #100_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Shadow insert: alternate tables, evicting occupants until a free slot or the limit
   function automatic outcome_type cuckoo_place(input logic [KEY_FIELD_BITS-1:0] key,
                                                input logic [POS_BITS-1:0] pos_one,
                                                input logic [POS_BITS-1:0] pos_two);
      slot_type    carry;
      slot_type    occupant;
      int unsigned kicks;
      int unsigned idx;
      bit          side;
      bit          failed;
      outcome_type res;
      carry  = '{1'b1, key, pos_one, pos_two};
      kicks  = 0;
      side   = 1'b0;
      failed = 1'b0;
      while (1) begin
         idx      = (side ? carry.pos_two : carry.pos_one) % TBL_DEPTH;
         occupant = side ? shadow_two[idx] : shadow_one[idx];
         if (occupant.valid && kicks >= kick_limit) begin
            failed = 1'b1;
            break;
         end
         if (side) shadow_two[idx] = carry;
         else      shadow_one[idx] = carry;
         if (!occupant.valid) break;
         carry = occupant;
         kicks++;
         side = !side;
      end
      res        = '0;
      res.status = failed ? chi_pkg::STATUS_FAILED : chi_pkg::STATUS_PLACED;
      res.kicks  = kicks[KICK_BITS-1:0];
      if (failed) begin
         res.key     = carry.key;
         res.pos_one = carry.pos_one;
         res.pos_two = carry.pos_two;
      end
      return res;
   endfunction

   // Mostly short gaps, some medium, a few long
   function automatic int unsigned pick_gap(input bit quiet);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   function automatic logic [KEY_FIELD_BITS-1:0] pick_key();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return recent_key;
         default: return $urandom;
      endcase
   endfunction

   // Narrow mode crowds keys onto the outer slots
   function automatic logic [POS_BITS-1:0] pick_pos(input bit narrow);
      if (narrow) return $urandom_range(0, 1) ? 3'd7 : 3'd0;
      return POS_BITS'($urandom_range(0, 7));
   endfunction

   // One insert transfer; the outcome is predicted when it is taken
   task automatic send_insert(input logic [KEY_FIELD_BITS-1:0] key,
                              input logic [POS_BITS-1:0] pos_one,
                              input logic [POS_BITS-1:0] pos_two,
                              input int unsigned gap,
                              input bit typed,
                              input outcome_type typed_want);
      outcome_type predicted;
      if (gap != 0) begin
         if (start) start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_new_key      <= key;
      req_hash_one_pos <= pos_one;
      req_hash_two_pos <= pos_two;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = cuckoo_place(key, pos_one, pos_two);
      pending_outcomes.push_back(typed ? typed_want : predicted);
      recent_key = key;
      inserts_sent++;
   endtask

   // Stop sending and let every outstanding outcome arrive
   task automatic settle();
      if (start) start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_kick_limit(input logic [KICK_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      kick_limit = value;
   endtask

   // Response checker: every strobe is matched against the oldest expectation
   always @(posedge clock) begin : rsp_check
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: response with none expected, actual status %0d kicks %0d key %h",
                     $time, rsp_status, rsp_kick_count, rsp_leftover_key);
            fault_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               fault_count++;
            end
            if (rsp_kick_count !== want.kicks) begin
               $display("%0t: kick_count expected %0d actual %0d",
                        $time, want.kicks, rsp_kick_count);
               fault_count++;
            end
            if (rsp_leftover_key !== want.key) begin
               $display("%0t: leftover_key expected %h actual %h",
                        $time, want.key, rsp_leftover_key);
               fault_count++;
            end
            if (rsp_leftover_pos_one !== want.pos_one) begin
               $display("%0t: leftover_pos_one expected %0d actual %0d",
                        $time, want.pos_one, rsp_leftover_pos_one);
               fault_count++;
            end
            if (rsp_leftover_pos_two !== want.pos_two) begin
               $display("%0t: leftover_pos_two expected %0d actual %0d",
                        $time, want.pos_two, rsp_leftover_pos_two);
               fault_count++;
            end
         end
      end
   end

   // Stimulus: directed plan, then random phases at assorted kick limits
   initial begin : stimulus
      int unsigned pick;
      int unsigned phase_len;
      bit          quiet;
      bit          narrow;
      logic [KICK_BITS-1:0] limit_value;

      reset            = 1'b1;
      start            = 1'b0;
      req_new_key      = '0;
      req_hash_one_pos = '0;
      req_hash_two_pos = '0;
      csr_valid        = 1'b0;
      csr_data         = '0;
      foreach (shadow_one[i]) shadow_one[i] = '0;
      foreach (shadow_two[i]) shadow_two[i] = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // clearing pass runs with busy high
      @(posedge clock);
      while (busy) @(posedge clock);

      foreach (DIRECTED_PLAN[i]) begin
         if (DIRECTED_PLAN[i].op == STEP_LIMIT) begin
            settle();
            write_kick_limit(DIRECTED_PLAN[i].limit);
         end else begin
            send_insert(DIRECTED_PLAN[i].key, DIRECTED_PLAN[i].pos_one,
                        DIRECTED_PLAN[i].pos_two, pick_gap(1'b0),
                        DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
         end
      end

      while (inserts_sent < ITEM_TARGET) begin
         settle();
         pick = $urandom_range(0, 99);
         if (pick < 8)       limit_value = '0;
         else if (pick < 12) limit_value = '1;
         else if (pick < 22) limit_value = KICK_BITS'($urandom_range(7, 64));
         else                limit_value = KICK_BITS'($urandom_range(1, 6));
         write_kick_limit(limit_value);
         // long chains are slow, so keep those phases short
         phase_len = (limit_value > 64) ? $urandom_range(2, 5) : $urandom_range(20, 80);
         quiet     = ($urandom_range(0, 3) == 0);
         narrow    = ($urandom_range(0, 3) == 0);
         repeat (phase_len) begin
            if ($urandom_range(0, 49) == 0) settle();
            send_insert(pick_key(), pick_pos(narrow), pick_pos(narrow),
                        pick_gap(quiet), 1'b0, NO_OUTCOME);
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (fault_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
